### design/nearest_centroid_assigner_assert.svh
// assertion macros for the nearest centroid assigner checker
`ifndef NEAREST_CENTROID_ASSIGNER_ASSERT_SVH
`define NEAREST_CENTROID_ASSIGNER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define NCA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define NCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/nca_pkg.sv
// shared types and constants for the nearest centroid assigner
`timescale 1ns / 1ps
`default_nettype none

package nca_pkg;

    // centroid bank and dimension count, tied to the index field widths below
    localparam int MAX_CLUSTERS   = 16;
    localparam int MAX_DIMENSIONS = 64;

    // fixed field widths of the item and result transfers
    localparam int CIDX_W      = 4;
    localparam int DIM_W       = 6;
    localparam int LABEL_OUT_W = 4;
    localparam int ACC_W       = 40;
    localparam int COUNT_W     = 5;
    localparam int APB_DATA_W  = 32;
    localparam int PADDR_W     = 3;

    localparam logic [ACC_W-1:0]   ACC_MAX     = {ACC_W{1'b1}};
    localparam logic [63:0]        SQ_LIMIT    = 64'h0000_0000_0010_0000;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd1;

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_POINT = 1'b1
    } nca_opcode_t;

    // register index, taken from the word address bit
    typedef enum logic
    {
        REG_CENTROID_COUNT = 1'b0
    } nca_reg_t;

    typedef struct packed
    {
        logic              valid;
        nca_opcode_t       opcode;
        logic [CIDX_W-1:0] cidx;
        logic [DIM_W-1:0]  dim;
        logic              last;
    } nca_ctrl_t;

endpackage

`default_nettype wire

### design/nearest_centroid_assigner.sv
// top level of the nearest centroid assigner: cell chain, apb register and result register
`timescale 1ns / 1ps
`default_nettype none

// k-means assignment step. every item, load or point coordinate, enters a chain of
// MAX_CLUSTERS identical cells, one per centroid, and moves along it one cell at a
// time; each cell holds the coordinates of its centroid in a small ram. a load item
// writes the coordinate into the cell that owns its centroid_index. a point item reads
// the centroid coordinate in each cell, adds the saturated squared difference to that
// cell's 40-bit accumulator and, on the last coordinate, folds the accumulator into a
// running (label, distance) minimum carried along the chain; strict less-than keeps the
// lowest index on ties. an item is taken every cycle while in_ready is high. once its
// last coordinate is transferred, the item loads the first of the three register
// stages of cell 0 on its transfer edge, passes the three stages of each cell (ram
// read, square, accumulate) and lands in the output register as a valid result.
// the only stall comes from the output register: when it holds a result that is not
// taken and the next result reaches the end of the chain, the whole chain holds and
// in_ready drops.
// centroid_count sits at byte address 0 and may only be written while no point is in
// flight; a centroid coordinate that was never loaded gives an undefined distance.
module nearest_centroid_assigner #(
    parameter int VALUE_WIDTH    = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // item channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               opcode,
    input  logic [nca_pkg::CIDX_W-1:0]         centroid_index,
    input  logic [nca_pkg::DIM_W-1:0]          dim_index,
    input  logic signed [VALUE_WIDTH-1:0]      coord_value,
    input  logic                               last_coordinate,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [nca_pkg::LABEL_OUT_W-1:0]    cluster_label,
    output logic [nca_pkg::ACC_W-1:0]          best_distance,
    // apb register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [nca_pkg::PADDR_W-1:0]        paddr,
    input  logic [nca_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [nca_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    import nca_pkg::*;

    localparam int LABEL_W = $clog2(MAX_CLUSTERS);

    // chain links, index 0 is the input side
    nca_ctrl_t              chain_ctrl  [MAX_CLUSTERS+1];
    logic [VALUE_WIDTH-1:0] chain_value [MAX_CLUSTERS+1];
    logic [LABEL_W-1:0]     chain_label [MAX_CLUSTERS+1];
    logic [ACC_W-1:0]       chain_dist  [MAX_CLUSTERS+1];

    logic [MAX_CLUSTERS-1:0] cell_en;
    logic                    advance;
    logic                    tail_result;
    logic                    cfg_write;

    logic [COUNT_W-1:0]     centroid_count_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [LABEL_OUT_W-1:0] out_label_reg;
    logic [ACC_W-1:0]       out_dist_reg;

    // the value of the last link is only consumed by a further cell
    logic                   unused_tail_value;

    // ---------------- configuration register ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_CENTROID_COUNT)
                     ? APB_DATA_W'(centroid_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centroid_count_reg <= COUNT_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_CENTROID_COUNT))
        begin
            centroid_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // ---------------- flow control ----------------
    // the chain holds only when a result reaches its end and the output is still full
    assign tail_result = chain_ctrl[MAX_CLUSTERS].valid
                      && (chain_ctrl[MAX_CLUSTERS].opcode == OP_POINT)
                      && chain_ctrl[MAX_CLUSTERS].last;
    assign advance     = !(tail_result && out_valid_reg && !out_ready);
    assign in_ready    = advance;

    // ---------------- chain head ----------------
    assign chain_ctrl[0].valid  = in_valid;
    assign chain_ctrl[0].opcode = nca_opcode_t'(opcode);
    assign chain_ctrl[0].cidx   = centroid_index;
    assign chain_ctrl[0].dim    = dim_index;
    assign chain_ctrl[0].last   = last_coordinate;
    assign chain_value[0]       = coord_value;
    // cell 0 always seeds the minimum, so the head's candidate is never used
    assign chain_label[0]       = '0;
    assign chain_dist[0]        = '0;

    // ---------------- centroid cells ----------------
    for (genvar k = 0; k < MAX_CLUSTERS; k++)
    begin : g_cell
        // count of zero behaves as one; above the cell count all cells compare
        assign cell_en[k] = (k == 0) || (32'(centroid_count_reg) > 32'(k));

        nca_cell #(
            .CELL_INDEX     (k),
            .MAX_DIMENSIONS (MAX_DIMENSIONS),
            .VALUE_WIDTH    (VALUE_WIDTH),
            .LABEL_W        (LABEL_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .enable    (cell_en[k]),
            .ctrl_in   (chain_ctrl[k]),
            .value_in  (chain_value[k]),
            .label_in  (chain_label[k]),
            .dist_in   (chain_dist[k]),
            .ctrl_out  (chain_ctrl[k+1]),
            .value_out (chain_value[k+1]),
            .label_out (chain_label[k+1]),
            .dist_out  (chain_dist[k+1])
        );
    end

    // ---------------- result register ----------------
    always_comb
    begin
        if (tail_result && advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail_result && advance)
        begin
            out_label_reg <= LABEL_OUT_W'(chain_label[MAX_CLUSTERS]);
            out_dist_reg  <= chain_dist[MAX_CLUSTERS];
        end
    end

    assign out_valid     = out_valid_reg;
    assign cluster_label = out_label_reg;
    assign best_distance = out_dist_reg;

    assign unused_tail_value = ^chain_value[MAX_CLUSTERS];

endmodule

`default_nettype wire

### design/nca_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module nca_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/nca_cell.sv
// one centroid cell: coordinate ram, squared difference, accumulator, running minimum
`timescale 1ns / 1ps
`default_nettype none

module nca_cell #(
    parameter int CELL_INDEX     = 0,
    parameter int MAX_DIMENSIONS = 64,
    parameter int VALUE_WIDTH    = 16,
    parameter int LABEL_W        = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        enable,
    input  nca_pkg::nca_ctrl_t          ctrl_in,
    input  logic [VALUE_WIDTH-1:0]      value_in,
    input  logic [LABEL_W-1:0]          label_in,
    input  logic [nca_pkg::ACC_W-1:0]   dist_in,
    output nca_pkg::nca_ctrl_t          ctrl_out,
    output logic [VALUE_WIDTH-1:0]      value_out,
    output logic [LABEL_W-1:0]          label_out,
    output logic [nca_pkg::ACC_W-1:0]   dist_out
);

    import nca_pkg::*;

    localparam int AW     = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;
    localparam int DIFF_W = VALUE_WIDTH + 1;
    localparam int SQ_W   = 2 * DIFF_W;

    // ram port
    logic                   load_hit;
    logic                   ram_we;
    logic [AW-1:0]          ram_addr;
    logic [VALUE_WIDTH-1:0] ram_rdata;

    // stage 1: centroid coordinate read back
    nca_ctrl_t              s1_ctrl_reg;
    logic [VALUE_WIDTH-1:0] s1_value_reg;
    logic [LABEL_W-1:0]     s1_label_reg;
    logic [ACC_W-1:0]       s1_dist_reg;
    logic [DIFF_W-1:0]      diff;
    logic [DIFF_W-1:0]      mag;
    logic [SQ_W-1:0]        square;
    logic                   s1_dim_ok;
    logic [ACC_W-1:0]       sq_next;

    // stage 2: accumulate and compare
    nca_ctrl_t              s2_ctrl_reg;
    logic [VALUE_WIDTH-1:0] s2_value_reg;
    logic [LABEL_W-1:0]     s2_label_reg;
    logic [ACC_W-1:0]       s2_dist_reg;
    logic [ACC_W-1:0]       s2_sq_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [ACC_W-1:0]       acc_next;
    logic [ACC_W:0]         acc_sum;
    logic [ACC_W-1:0]       acc_new;
    logic                   is_point;
    logic                   take;
    logic [LABEL_W-1:0]     label_next;
    logic [ACC_W-1:0]       dist_next;

    // output stage, seen by the next cell
    nca_ctrl_t              out_ctrl_reg;
    logic [VALUE_WIDTH-1:0] out_value_reg;
    logic [LABEL_W-1:0]     out_label_reg;
    logic [ACC_W-1:0]       out_dist_reg;

    assign ram_addr = AW'(ctrl_in.dim);
    assign load_hit = ctrl_in.valid && (ctrl_in.opcode == OP_LOAD)
                   && (32'(ctrl_in.cidx) == 32'(CELL_INDEX))
                   && (32'(ctrl_in.dim) < 32'(MAX_DIMENSIONS));
    assign ram_we   = advance && load_hit;

    nca_ram #(
        .WIDTH  (VALUE_WIDTH),
        .DEPTH  (MAX_DIMENSIONS),
        .ADDR_W (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (value_in),
        .re    (advance),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    // exact difference, magnitude and saturated square
    always_comb
    begin
        diff      = {ram_rdata[VALUE_WIDTH-1], ram_rdata}
                  - {s1_value_reg[VALUE_WIDTH-1], s1_value_reg};
        mag       = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
        square    = SQ_W'(mag) * SQ_W'(mag);
        s1_dim_ok = 32'(s1_ctrl_reg.dim) < 32'(MAX_DIMENSIONS);
        if (!s1_dim_ok)
        begin
            sq_next = '0;
        end
        else if (64'(mag) >= SQ_LIMIT)
        begin
            sq_next = ACC_MAX;
        end
        else
        begin
            sq_next = ACC_W'(square);
        end
    end

    // saturating accumulate, then keep the running minimum
    always_comb
    begin
        acc_sum    = {1'b0, acc_reg} + {1'b0, s2_sq_reg};
        acc_new    = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
        is_point   = s2_ctrl_reg.valid && (s2_ctrl_reg.opcode == OP_POINT);
        take       = (CELL_INDEX == 0) || (enable && (acc_new < s2_dist_reg));
        label_next = take ? LABEL_W'(CELL_INDEX) : s2_label_reg;
        dist_next  = take ? acc_new : s2_dist_reg;
        if (is_point)
        begin
            acc_next = s2_ctrl_reg.last ? '0 : acc_new;
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg  <= '0;
            s2_ctrl_reg  <= '0;
            out_ctrl_reg <= '0;
            acc_reg      <= '0;
        end
        else if (advance)
        begin
            s1_ctrl_reg  <= ctrl_in;
            s2_ctrl_reg  <= s1_ctrl_reg;
            out_ctrl_reg <= s2_ctrl_reg;
            acc_reg      <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_value_reg  <= value_in;
            s1_label_reg  <= label_in;
            s1_dist_reg   <= dist_in;
            s2_value_reg  <= s1_value_reg;
            s2_label_reg  <= s1_label_reg;
            s2_dist_reg   <= s1_dist_reg;
            s2_sq_reg     <= sq_next;
            out_value_reg <= s2_value_reg;
            out_label_reg <= label_next;
            out_dist_reg  <= dist_next;
        end
    end

    assign ctrl_out  = out_ctrl_reg;
    assign value_out = out_value_reg;
    assign label_out = out_label_reg;
    assign dist_out  = out_dist_reg;

endmodule

`default_nettype wire

### design/nca_checker.sv
// port-level checker for the nearest centroid assigner and its bind
`timescale 1ns / 1ps
`default_nettype none

`include "nearest_centroid_assigner_assert.svh"

module nca_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [nca_pkg::LABEL_OUT_W-1:0] cluster_label,
    input logic [nca_pkg::ACC_W-1:0]       best_distance,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic                            pready,
    input logic [nca_pkg::PADDR_W-1:0]     paddr,
    input logic [nca_pkg::APB_DATA_W-1:0]  pwdata,
    input logic [nca_pkg::APB_DATA_W-1:0]  prdata
);

    import nca_pkg::*;

    // a stalled result keeps its payload
    `NCA_ASSERT_NEXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(cluster_label) && $stable(best_distance), "result changed while stalled")

    // with the output register empty nothing may hold the chain
    `NCA_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")

    // a count write reads back on the next cycle
    `NCA_ASSERT_NEXT(a_count_readback, psel && penable && pwrite && pready && (paddr[2] == REG_CENTROID_COUNT), (paddr[2] != REG_CENTROID_COUNT) || (prdata[COUNT_W-1:0] == $past(pwdata[COUNT_W-1:0])), "centroid count readback mismatch")

    // no result can be present right after reset
    `NCA_ASSERT_SAME(a_empty_after_reset, $rose(rst_n), !out_valid, "result present after reset")

endmodule

bind nearest_centroid_assigner nca_checker u_nca_checker (.*);

`default_nettype wire

### test/nearest_centroid_assigner_tb.sv
// self-checking testbench for the nearest centroid assigner
`timescale 1ns / 1ps

module nearest_centroid_assigner_tb;

    import nca_pkg::*;

    localparam int NUM_CENTROIDS    = 16;
    localparam int NUM_DIMS         = 64;
    localparam int VALUE_W          = 16;
    // result passes the register stages of every cell after the last coordinate transfer
    localparam int CHAIN_LATENCY    = 3 * NUM_CENTROIDS;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 16'sh7FFF;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 16'sh8000;
    // dimensions loaded for every centroid up front, so points can always use them
    localparam logic [8*DIM_W-1:0] BASE_DIMS =
        {6'd63, 6'd62, 6'd42, 6'd21, 6'd3, 6'd2, 6'd1, 6'd0};

    typedef struct {
        nca_opcode_t               op;
        logic [CIDX_W-1:0]         cidx;
        logic [DIM_W-1:0]          dim;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } coord_item_t;

    typedef struct {
        logic [LABEL_OUT_W-1:0] label;
        logic [ACC_W-1:0]       distance;
    } assignment_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // item channel
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      opcode = 1'b0;
    logic [CIDX_W-1:0]         centroid_index = '0;
    logic [DIM_W-1:0]          dim_index = '0;
    logic signed [VALUE_W-1:0] coord_value = '0;
    logic                      last_coordinate = 1'b0;

    // result channel
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [LABEL_OUT_W-1:0] cluster_label;
    logic [ACC_W-1:0]       best_distance;

    // register port
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // stimulus side
    coord_item_t pending_items[$];
    coord_item_t bus_item;
    bit          gen_loaded [NUM_CENTROIDS][NUM_DIMS];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        hold_request = 1'b0;
    logic        hold_results = 1'b0;

    // predicted block state
    logic signed [VALUE_W-1:0] centroid_copy [NUM_CENTROIDS][NUM_DIMS];
    logic [ACC_W-1:0]          distance_sum [NUM_CENTROIDS];
    logic [COUNT_W-1:0]        count_setting = COUNT_RESET;
    assignment_t               expected_assignments[$];
    int                        error_count = 0;

    nearest_centroid_assigner u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .centroid_index  (centroid_index),
        .dim_index       (dim_index),
        .coord_value     (coord_value),
        .last_coordinate (last_coordinate),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .cluster_label   (cluster_label),
        .best_distance   (best_distance),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // accumulator bank starts cleared
    initial
    begin
        for (int k = 0; k < NUM_CENTROIDS; k++)
        begin
            distance_sum[k] = '0;
        end
    end

    // ------------------------------------------------------------------
    // prediction: one accepted item against the local copy of the block
    // ------------------------------------------------------------------
    task automatic accumulate_coordinate(input coord_item_t it);
        longint      diff;
        longint      square;
        longint      sum;
        int          in_use;
        int          k;
        assignment_t pick;
        if (it.op == OP_LOAD)
        begin
            // the last flag on a load never produces a result
            centroid_copy[it.cidx][it.dim] = it.value;
            return;
        end
        // every accumulator moves, whatever the count
        for (k = 0; k < NUM_CENTROIDS; k++)
        begin
            diff = longint'(centroid_copy[k][it.dim]) - longint'(it.value);
            if (diff < 0)
                diff = -diff;
            square = (diff >= longint'(SQ_LIMIT)) ? longint'(ACC_MAX) : diff * diff;
            sum = longint'(distance_sum[k]) + square;
            distance_sum[k] = (sum > longint'(ACC_MAX)) ? ACC_MAX : sum[ACC_W-1:0];
        end
        if (!it.last)
            return;
        // zero counts as one, anything past the bank is clamped
        in_use = int'(count_setting);
        if (in_use == 0)
            in_use = 1;
        if (in_use > NUM_CENTROIDS)
            in_use = NUM_CENTROIDS;
        pick.label = '0;
        pick.distance = distance_sum[0];
        // strict less-than keeps the lowest index on ties
        for (k = 1; k < in_use; k++)
        begin
            if (distance_sum[k] < pick.distance)
            begin
                pick.label = k[LABEL_OUT_W-1:0];
                pick.distance = distance_sum[k];
            end
        end
        for (k = 0; k < NUM_CENTROIDS; k++)
        begin
            distance_sum[k] = '0;
        end
        expected_assignments = {expected_assignments, pick};
    endtask

    // ------------------------------------------------------------------
    // item driver: one transfer per handshake, random gaps
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                accumulate_coordinate(bus_item);
            // present the next item only once the current one is gone
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    bus_item = pending_items.pop_front();
                    in_valid        <= 1'b1;
                    opcode          <= bus_item.op;
                    centroid_index  <= bus_item.cidx;
                    dim_index       <= bus_item.dim;
                    coord_value     <= bus_item.value;
                    last_coordinate <= bus_item.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result side: random stalls, plus the long hold-off when requested
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_results && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // long receiver hold-off, counted here so the sender keeps pushing meanwhile
    initial
    begin
        wait (hold_request);
        @(posedge clk);
        hold_results <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_results <= 1'b0;
    end

    // compare every result transfer against the oldest prediction
    always @(posedge clk)
    begin : result_check
        assignment_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_assignments.size() == 0)
            begin
                $error("unexpected result: cluster_label %0d best_distance %0d",
                       cluster_label, best_distance);
                error_count++;
            end
            else
            begin
                want = expected_assignments.pop_front();
                if (cluster_label !== want.label)
                begin
                    $error("cluster_label expected %0d actual %0d", want.label, cluster_label);
                    error_count++;
                end
                if (best_distance !== want.distance)
                begin
                    $error("best_distance expected %0d actual %0d",
                           want.distance, best_distance);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic signed [VALUE_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return '0;
            default: return VALUE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // a dimension a point may use: every centroid holds a value there
    function automatic bit dim_fully_loaded(input logic [DIM_W-1:0] d);
        for (int c = 0; c < NUM_CENTROIDS; c++)
        begin
            if (!gen_loaded[c][d])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [DIM_W-1:0] pick_point_dim();
        logic [DIM_W-1:0] d;
        for (int t = 0; t < 6; t++)
        begin
            d = DIM_W'($urandom_range(0, NUM_DIMS - 1));
            if (dim_fully_loaded(d))
                return d;
        end
        return BASE_DIMS[$urandom_range(0, 7) * DIM_W +: DIM_W];
    endfunction

    task automatic push_load(input int c, input int d, input logic signed [VALUE_W-1:0] v,
                             input logic last);
        coord_item_t it;
        it.op    = OP_LOAD;
        it.cidx  = c[CIDX_W-1:0];
        it.dim   = d[DIM_W-1:0];
        it.value = v;
        it.last  = last;
        gen_loaded[it.cidx][it.dim] = 1'b1;
        pending_items = {pending_items, it};
    endtask

    // centroid_index is don't-care on points, so it toggles at random
    task automatic push_point(input int d, input logic signed [VALUE_W-1:0] v,
                              input logic last);
        coord_item_t it;
        it.op    = OP_POINT;
        it.cidx  = CIDX_W'($urandom_range(0, NUM_CENTROIDS - 1));
        it.dim   = d[DIM_W-1:0];
        it.value = v;
        it.last  = last;
        pending_items = {pending_items, it};
    endtask

    // mostly whole points with random content, some loads and loads flagged last
    task automatic queue_random_traffic(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                push_load($urandom_range(0, NUM_CENTROIDS - 1), $urandom_range(0, NUM_DIMS - 1),
                          rand_coord(), 1'($urandom_range(0, 1)));
                sent++;
            end
            else
            begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                begin
                    // an occasional centroid update in the middle of a point
                    if ($urandom_range(0, 19) == 0)
                    begin
                        push_load($urandom_range(0, NUM_CENTROIDS - 1),
                                  $urandom_range(0, NUM_DIMS - 1), rand_coord(), 1'b0);
                        sent++;
                    end
                    push_point(pick_point_dim(), rand_coord(), i == len - 1);
                    sent++;
                end
            end
        end
    endtask

    task automatic set_idling(input int pattern);
        case (pattern % 4)
            0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            1: begin send_idle_pct = 55; recv_idle_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_idle_pct = 55; end
            default: begin send_idle_pct = 6; recv_idle_pct = 6; end
        endcase
    endtask

    // sender pause: everything sent, every result back, chain flushed of loads
    task automatic wait_until_idle();
        int waited;
        waited = 0;
        while (pending_items.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_assignments.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_assignments.size() != 0)
        begin
            $error("%0d results never arrived", expected_assignments.size());
            error_count++;
            expected_assignments.delete();
        end
        repeat (CHAIN_LATENCY + 12) @(posedge clk);
    endtask

    // setup cycle, access cycle; the write lands on the access edge
    task automatic write_centroid_count(input logic [COUNT_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(REG_CENTROID_COUNT));
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        count_setting = value;
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int phase;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every centroid gets the base dimensions, reset count of one in force
        set_idling(0);
        for (int b = 0; b < 8; b++)
        begin
            for (int c = 0; c < NUM_CENTROIDS; c++)
            begin
                push_load(c, BASE_DIMS[b * DIM_W +: DIM_W], rand_coord(), 1'b0);
            end
        end
        // last flag on a load is ignored
        push_load(4, 1, rand_coord(), 1'b1);
        push_point(0, rand_coord(), 1'b1);
        // field extremes, and a point with the same dimension twice
        push_point(63, VAL_MAX, 1'b0);
        push_point(63, VAL_MIN, 1'b1);
        wait_until_idle();

        // full bank
        write_centroid_count(5'd16);
        set_idling(1);
        // centroids 7 and 9 share a coordinate so the tie goes to 7
        for (int c = 0; c < NUM_CENTROIDS; c++)
        begin
            push_load(c, 62, VALUE_W'(-32000 + ((c == 9) ? 7 : c) * 4000), 1'b0);
        end
        push_point(62, VALUE_W'(-32000 + 7 * 4000), 1'b1);
        push_point(62, VAL_MAX, 1'b1);
        // every accumulator saturates: all equal, label 0 wins
        for (int c = 0; c < NUM_CENTROIDS; c++)
        begin
            push_load(c, 21, VAL_MIN, 1'b0);
        end
        for (int i = 0; i < 270; i++)
        begin
            push_point(21, VAL_MAX, i == 269);
        end
        push_point(1, rand_coord(), 1'b0);
        push_point(1, rand_coord(), 1'b0);
        push_point(1, rand_coord(), 1'b1);
        wait_until_idle();

        // zero behaves as one
        write_centroid_count(5'd0);
        set_idling(2);
        queue_random_traffic(60);
        wait_until_idle();

        // above the bank size clamps to the full bank
        write_centroid_count(5'd31);
        set_idling(3);
        queue_random_traffic(60);
        wait_until_idle();

        write_centroid_count(5'd17);
        set_idling(0);
        queue_random_traffic(60);
        wait_until_idle();

        // random counts across all idling mixes
        for (phase = 0; phase < 4; phase++)
        begin
            write_centroid_count(COUNT_W'($urandom_range(1, NUM_CENTROIDS)));
            set_idling(phase);
            queue_random_traffic(40);
            wait_until_idle();
        end

        // back-pressure: results held off while single-coordinate points keep coming
        write_centroid_count(COUNT_W'($urandom_range(2, NUM_CENTROIDS)));
        set_idling(0);
        hold_request = 1'b1;
        for (int i = 0; i < 100; i++)
        begin
            push_point(pick_point_dim(), rand_coord(), 1'b1);
        end
        wait_until_idle();

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2ms;
        $display("Verification failed");
        $finish;
    end

endmodule
